FILE: src/flux_integration_commutator_macros.svh
// assertion macros shared by the flux integration commutator rtl
// expects clk and rst (synchronous, active high) in the scope of each use
`ifndef FLUX_INTEGRATION_COMMUTATOR_MACROS_SVH
`define FLUX_INTEGRATION_COMMUTATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define FIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fic_pkg.sv
// package for the flux integration commutator: widths, register codes,
// sample struct and the floating phase lookup; depends on nothing
`default_nettype none

package fic_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int THRESHOLD_BITS = 16;
  localparam int FLUX_BITS      = 17;
  localparam int SECTOR_BITS    = 3;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  =
    (SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS;

  localparam logic [SAMPLE_BITS-1:0]    NEUTRAL_RESET   = SAMPLE_BITS'(238);
  localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = THRESHOLD_BITS'(200);
  localparam logic [FLUX_BITS-1:0]      FLUX_MAX        = {FLUX_BITS{1'b1}};
  localparam logic [SECTOR_BITS-1:0]    LAST_SECTOR     = SECTOR_BITS'(5);

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEUTRAL_LEVEL  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FLUX_THRESHOLD = 1'b1;

  // floating phase codes
  localparam logic [1:0] PHASE_A    = 2'd0;
  localparam logic [1:0] PHASE_B    = 2'd1;
  localparam logic [1:0] PHASE_C    = 2'd2;
  localparam logic [1:0] PHASE_NONE = 2'd3;

  // signs: bit0 a, bit1 b, bit2 c, set when at or above neutral
  typedef struct packed {
    logic [2:0]                  signs;
    logic [2:0][SAMPLE_BITS-1:0] mag;
  } fic_sample_t;

  function automatic logic [1:0] floating_phase(input logic [SECTOR_BITS-1:0] s);
    logic [1:0] fp;
    case (s) inside
      3'd0, 3'd3: fp = PHASE_C;
      3'd1, 3'd4: fp = PHASE_B;
      3'd2, 3'd5: fp = PHASE_A;
      default:    fp = PHASE_NONE;
    endcase
    return fp;
  endfunction

endpackage

`default_nettype wire

FILE: src/fic_in_if.sv
// input channel: one set of three phase samples per transaction
// depends on fic_pkg for the sample width
`default_nettype none

interface fic_in_if;
  logic                         valid;
  logic                         ready;
  logic [fic_pkg::SAMPLE_BITS-1:0] phase_a;
  logic [fic_pkg::SAMPLE_BITS-1:0] phase_b;
  logic [fic_pkg::SAMPLE_BITS-1:0] phase_c;

  modport source (output valid, output phase_a, output phase_b, output phase_c,
                  input ready);
  modport sink   (input valid, input phase_a, input phase_b, input phase_c,
                  output ready);
endinterface

`default_nettype wire

FILE: src/fic_out_if.sv
// result channel: sector, commutation pulse, integration flag and flux sum
// depends on fic_pkg for the field widths
`default_nettype none

interface fic_out_if;
  logic                              valid;
  logic                              ready;
  logic [fic_pkg::SECTOR_BITS-1:0] sector_now;
  logic                              commutate;
  logic                              integrating;
  logic [fic_pkg::FLUX_BITS-1:0]   flux_total;

  modport source (output valid, output sector_now, output commutate,
                  output integrating, output flux_total, input ready);
  modport sink   (input valid, input sector_now, input commutate,
                  input integrating, input flux_total, output ready);
endinterface

`default_nettype wire

FILE: src/fic_frontend.sv
// input stage: neutral subtraction, sign and magnitude per phase, registered
// depends on fic_pkg and fic_in_if
`default_nettype none

module fic_frontend (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [fic_pkg::SAMPLE_BITS-1:0] neutral_level,
  fic_in_if.sink                               in_ch,
  input  wire logic                            take,
  output fic_pkg::fic_sample_t                 sample,
  output logic                                 sample_valid
);

  fic_pkg::fic_sample_t            sample_next;
  logic [2:0][fic_pkg::SAMPLE_BITS-1:0] raw;

  assign raw = {in_ch.phase_c, in_ch.phase_b, in_ch.phase_a};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (raw[i] >= neutral_level) begin
        sample_next.signs[i] = 1'b1;
        sample_next.mag[i]   = raw[i] - neutral_level;
      end else begin
        sample_next.signs[i] = 1'b0;
        sample_next.mag[i]   = neutral_level - raw[i];
      end
    end
  end

  assign in_ch.ready = !sample_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_ch.ready) begin
      sample_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample <= sample_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/fic_core.sv
// sector state, flux integration and result register
// depends on fic_pkg, fic_out_if and the assertion macro header
`default_nettype none
`include "flux_integration_commutator_macros.svh"

module fic_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [fic_pkg::THRESHOLD_BITS-1:0] flux_threshold,
  input  wire logic                               sample_valid,
  input  wire fic_pkg::fic_sample_t               sample,
  output logic                                    take,
  fic_out_if.source                               out_ch
);

  logic [fic_pkg::SECTOR_BITS-1:0] sector, sector_next;
  logic [2:0]                      previous_signs;
  logic                            accumulating, accumulating_next;
  logic [fic_pkg::FLUX_BITS-1:0]   flux_sum, flux_sum_next;
  logic                            commutate_next;
  logic                            load;

  logic [1:0]                      fp;
  logic                            fp_valid;
  logic                            sign_flip;
  logic                            active;
  logic [fic_pkg::SAMPLE_BITS-1:0] fp_mag;
  logic [fic_pkg::FLUX_BITS-1:0]   sum_base;
  logic [fic_pkg::FLUX_BITS:0]     sum_wide;
  logic [fic_pkg::FLUX_BITS-1:0]   sum_sat;

  assign take = !out_ch.valid || out_ch.ready;
  assign load = sample_valid && take;

  assign fp       = fic_pkg::floating_phase(sector);
  assign fp_valid = (fp != fic_pkg::PHASE_NONE);

  always_comb begin
    case (fp)
      fic_pkg::PHASE_A: begin
        sign_flip = sample.signs[0] ^ previous_signs[0];
        fp_mag    = sample.mag[0];
      end
      fic_pkg::PHASE_B: begin
        sign_flip = sample.signs[1] ^ previous_signs[1];
        fp_mag    = sample.mag[1];
      end
      fic_pkg::PHASE_C: begin
        sign_flip = sample.signs[2] ^ previous_signs[2];
        fp_mag    = sample.mag[2];
      end
      default: begin
        sign_flip = 1'b0;
        fp_mag    = '0;
      end
    endcase
  end

  // a zero crossing on the floating phase, when not integrating, restarts the sum at zero
  always_comb begin
    active   = accumulating || (fp_valid && sign_flip);
    sum_base = accumulating ? flux_sum : '0;
    sum_wide = {1'b0, sum_base}
             + (fic_pkg::FLUX_BITS + 1)'(fp_mag);
    sum_sat  = sum_wide[fic_pkg::FLUX_BITS] ? fic_pkg::FLUX_MAX
                                            : sum_wide[fic_pkg::FLUX_BITS-1:0];
    flux_sum_next     = active ? sum_sat : flux_sum;
    commutate_next    = active
                     && (flux_sum_next > fic_pkg::FLUX_BITS'(flux_threshold));
    accumulating_next = active && !commutate_next;
    if (commutate_next) begin
      sector_next = (sector >= fic_pkg::LAST_SECTOR) ? '0
                  : sector + fic_pkg::SECTOR_BITS'(1);
    end else begin
      sector_next = sector;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sector         <= '0;
      previous_signs <= '0;
      accumulating   <= 1'b0;
      flux_sum       <= '0;
      out_ch.valid   <= 1'b0;
    end else begin
      if (load) begin
        sector         <= sector_next;
        previous_signs <= sample.signs;
        accumulating   <= accumulating_next;
        flux_sum       <= flux_sum_next;
      end
      if (take) begin
        out_ch.valid <= sample_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.sector_now  <= sector_next;
      out_ch.commutate   <= commutate_next;
      out_ch.integrating <= accumulating_next;
      out_ch.flux_total  <= flux_sum_next;
    end
  end

  `FIC_ASSERT_NOW(a_sector_range, 1'b1, sector <= fic_pkg::LAST_SECTOR, "sector out of range")
  `FIC_ASSERT_NOW(a_commutate_stops, out_ch.valid && out_ch.commutate, !out_ch.integrating, "integrating after commutation")
  `FIC_ASSERT_NEXT(a_state_holds, !load, $stable(sector) && $stable(accumulating) && $stable(flux_sum), "state moved without a transaction")
  `FIC_ASSERT_NEXT(a_commutate_over_threshold, load && commutate_next, out_ch.flux_total > fic_pkg::FLUX_BITS'($past(flux_threshold)), "commutation below threshold")

endmodule

`default_nettype wire

FILE: src/flux_integration_commutator.sv
// Sensorless commutation by back-emf flux integration.
// in_ch carries one transaction per ADC sample set (phase_a, phase_b, phase_c);
// out_ch returns exactly one result per sample: sector_now, commutate (one
// sample pulse on a sector advance), integrating and flux_total.
// The configuration port writes neutral_level (index 0) and flux_threshold
// (index 1) on any edge with cfg_we high; write only while the block is idle.
// From input acceptance to result valid, the phase magnitudes are registered
// in the front end, then the flux add, saturate and threshold compare land
// in the result register.
// Throughput is one sample per cycle while the receiver is ready; the sector
// and flux state is updated as each sample enters the result register, so
// consecutive samples chain through that single register stage.
// A stalled receiver holds the result; the front end keeps one more sample,
// and in_ch.ready drops only when both stages are full.
// Synchronous reset clears both stages, sets sector 0, clears the stored
// signs and the flux sum, and loads the register reset values (238, 200).
// depends on fic_pkg, fic_in_if, fic_out_if, fic_frontend and fic_core
`default_nettype none

module flux_integration_commutator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [fic_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [fic_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  fic_in_if.sink                                 in_ch,
  fic_out_if.source                              out_ch
);

  logic [fic_pkg::SAMPLE_BITS-1:0]    neutral_level;
  logic [fic_pkg::THRESHOLD_BITS-1:0] flux_threshold;
  fic_pkg::fic_sample_t               sample;
  logic                               sample_valid;
  logic                               take;

  always_ff @(posedge clk) begin
    if (rst) begin
      neutral_level  <= fic_pkg::NEUTRAL_RESET;
      flux_threshold <= fic_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fic_pkg::REG_NEUTRAL_LEVEL:
          neutral_level <= cfg_data[fic_pkg::SAMPLE_BITS-1:0];
        fic_pkg::REG_FLUX_THRESHOLD:
          flux_threshold <= cfg_data[fic_pkg::THRESHOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  fic_frontend u_frontend (
    .clk          (clk),
    .rst          (rst),
    .neutral_level(neutral_level),
    .in_ch        (in_ch),
    .take         (take),
    .sample       (sample),
    .sample_valid (sample_valid)
  );

  fic_core u_core (
    .clk           (clk),
    .rst           (rst),
    .flux_threshold(flux_threshold),
    .sample_valid  (sample_valid),
    .sample        (sample),
    .take          (take),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// self-checking bench for flux_integration_commutator: a commutation predictor
// in a scoreboard class, directed and random sample sets, random stalls
// depends on fic_pkg, fic_in_if, fic_out_if and the block itself

module tb;
  import fic_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_PHASES  = 8;
  localparam int NUM_DIRECTED = 12;

  typedef struct {
    logic [SECTOR_BITS-1:0] sector_now;
    logic                   commutate;
    logic                   integrating;
    logic [FLUX_BITS-1:0]   flux_total;
  } commutation_t;

  class commutation_scoreboard;
    logic [SAMPLE_BITS-1:0]    neutral;
    logic [THRESHOLD_BITS-1:0] threshold;
    logic [SECTOR_BITS-1:0]    sector;
    logic [2:0]                last_signs;
    bit                        active;
    logic [FLUX_BITS-1:0]      flux;
    commutation_t              expected_q[$];
    int                        errors;

    function new();
      neutral    = NEUTRAL_RESET;
      threshold  = THRESHOLD_RESET;
      sector     = '0;
      last_signs = '0;
      active     = 1'b0;
      flux       = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_NEUTRAL_LEVEL)
        neutral = data[SAMPLE_BITS-1:0];
      else if (idx == REG_FLUX_THRESHOLD)
        threshold = data[THRESHOLD_BITS-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // advance the commutation state by one accepted sample set
    function void note_sample(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b,
                              logic [SAMPLE_BITS-1:0] c);
      logic [SAMPLE_BITS-1:0] v[3];
      logic [SAMPLE_BITS-1:0] mag[3];
      logic [2:0]             signs;
      logic [1:0]             fp;
      logic [FLUX_BITS:0]     sum;
      commutation_t           r;
      v[0] = a;
      v[1] = b;
      v[2] = c;
      signs = '0;
      for (int i = 0; i < 3; i++) begin
        if (v[i] >= neutral) begin
          signs[i] = 1'b1;
          mag[i] = v[i] - neutral;
        end else begin
          mag[i] = neutral - v[i];
        end
      end
      case (sector)
        3'd0, 3'd3: fp = PHASE_C;
        3'd1, 3'd4: fp = PHASE_B;
        3'd2, 3'd5: fp = PHASE_A;
        default:    fp = PHASE_NONE;
      endcase
      if (!active && fp != PHASE_NONE && signs[fp] != last_signs[fp]) begin
        active = 1'b1;
        flux = '0;
      end
      last_signs = signs;
      r.commutate = 1'b0;
      if (active) begin
        if (fp != PHASE_NONE) begin
          sum = {1'b0, flux} + (FLUX_BITS + 1)'(mag[fp]);
          flux = (sum > {1'b0, FLUX_MAX}) ? FLUX_MAX : sum[FLUX_BITS-1:0];
        end
        if (flux > FLUX_BITS'(threshold)) begin
          sector = (sector >= LAST_SECTOR) ? '0 : sector + SECTOR_BITS'(1);
          active = 1'b0;
          r.commutate = 1'b1;
        end
      end
      r.sector_now  = sector;
      r.integrating = active;
      r.flux_total  = flux;
      expected_q.push_back(r);
    endfunction

    function void check_result(commutation_t got);
      commutation_t want;
      if (expected_q.size() == 0) begin
        $error("result with no sample pending");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.sector_now !== want.sector_now) begin
        $error("sector_now: expected %0d, got %0d", want.sector_now, got.sector_now);
        errors++;
      end
      if (got.commutate !== want.commutate) begin
        $error("commutate: expected %0d, got %0d", want.commutate, got.commutate);
        errors++;
      end
      if (got.integrating !== want.integrating) begin
        $error("integrating: expected %0d, got %0d", want.integrating, got.integrating);
        errors++;
      end
      if (got.flux_total !== want.flux_total) begin
        $error("flux_total: expected %0d, got %0d", want.flux_total, got.flux_total);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  bit                        calm;
  int                        stall_left;
  int                        cycles;
  commutation_scoreboard     sb;

  fic_in_if  in_ch();
  fic_out_if out_ch();

  flux_integration_commutator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #2 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // level around neutral, clamped to the adc range
  function automatic logic [SAMPLE_BITS-1:0] level_near(int centre, int span);
    int x;
    x = centre + int'($urandom_range(0, 2 * span)) - span;
    if (x < 0)
      x = 0;
    if (x > 1023)
      x = 1023;
    return x[SAMPLE_BITS-1:0];
  endfunction

  task automatic send_sample(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b,
                             logic [SAMPLE_BITS-1:0] c);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.phase_a <= a;
    in_ch.phase_b <= b;
    in_ch.phase_c <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(a, b, c);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [SAMPLE_BITS-1:0] neutral,
                            logic [THRESHOLD_BITS-1:0] threshold);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NEUTRAL_LEVEL;
    cfg_data  <= CFG_DATA_BITS'(neutral);
    @(posedge clk);
    cfg_index <= REG_FLUX_THRESHOLD;
    cfg_data  <= CFG_DATA_BITS'(threshold);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_NEUTRAL_LEVEL, CFG_DATA_BITS'(neutral));
    sb.write_reg(REG_FLUX_THRESHOLD, CFG_DATA_BITS'(threshold));
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20)
        stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    commutation_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.sector_now  = out_ch.sector_now;
      got.commutate   = out_ch.commutate;
      got.integrating = out_ch.integrating;
      got.flux_total  = out_ch.flux_total;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL flux_integration_commutator");
      $finish;
    end
  end

  initial begin
    logic [SAMPLE_BITS-1:0]    directed[NUM_DIRECTED][3];
    logic [SAMPLE_BITS-1:0]    neutral_set[NUM_PHASES];
    logic [THRESHOLD_BITS-1:0] threshold_set[NUM_PHASES];
    int                        span_set[NUM_PHASES];
    int                        count_set[NUM_PHASES];
    int                        centre;
    // signs at neutral, immediate commutation on the start sample, bit patterns
    directed = '{'{10'd0, 10'd0, 10'd0}, '{10'd238, 10'd238, 10'd238},
                 '{10'd1023, 10'd1023, 10'd1023}, '{10'd1023, 10'd0, 10'd1023},
                 '{10'd0, 10'd0, 10'd0}, '{10'd0, 10'd0, 10'd300},
                 '{10'd0, 10'd0, 10'd400}, '{10'h2AA, 10'h155, 10'h2AA},
                 '{10'h155, 10'h2AA, 10'h155}, '{10'd237, 10'd239, 10'd238},
                 '{10'd1023, 10'd1023, 10'd0}, '{10'd0, 10'd1023, 10'd1023}};
    // zero threshold, neutral at both ends, largest threshold, random setting
    neutral_set   = '{10'd512, 10'd0, 10'd1023, 10'd512, 10'd100, 10'd900,
                      10'($urandom_range(0, 1023)), 10'd238};
    threshold_set = '{16'd0, 16'd1000, 16'd50, 16'd65535, 16'd1, 16'd3000,
                      16'($urandom_range(0, 2000)), 16'd200};
    span_set      = '{40, 300, 300, 1023, 200, 400, 300, 300};
    count_set     = '{100, 80, 80, 300, 100, 120, 120, 100};

    sb            = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.phase_a = '0;
    in_ch.phase_b = '0;
    in_ch.phase_c = '0;
    out_ch.ready  = 1'b0;
    calm          = 1'b0;
    stall_left    = 0;
    cycles        = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_sample(directed[i][0], directed[i][1], directed[i][2]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(neutral_set[p], threshold_set[p]);
      calm = ($urandom_range(0, 3) == 0);
      centre = int'(neutral_set[p]);
      for (int n = 0; n < count_set[p]; n++) begin
        if ($urandom_range(0, 99) < 15)
          send_sample(10'($urandom), 10'($urandom), 10'($urandom));
        else
          send_sample(level_near(centre, span_set[p]), level_near(centre, span_set[p]),
                      level_near(centre, span_set[p]));
        if ($urandom_range(0, 99) == 0)
          drain();
      end
      drain();
    end

    calm = 1'b0;
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS flux_integration_commutator");
    else
      $display("FAIL flux_integration_commutator");
    $finish;
  end

endmodule
